### design/aroc_pkg.sv
// Shared package of the address range overlap checker.
// Holds default parameter values, field widths, command codes and the
// control and status structs between controller and datapath.
package aroc_pkg;

  // Default parameter values.
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int BANK_COUNT_DEF  = 256;
  localparam int BANK_SHIFT_DEF  = 16;

  // Fixed field widths.
  localparam int ADDR_W  = 32;
  localparam int BIDX_W  = 8;
  localparam int HITS_W  = 9;

  // The overlap count saturates at its largest code.
  localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

  // Command codes.
  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } aroc_cmd_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;    // write one zero flag of the clearing pass
    logic latch;       // capture the accepted input beat
    logic scan_en;     // issue one table read of the scan
    logic store_en;    // append the range and settle the full flag
    logic flag_rd_en;  // read the requested bank flag
    logic out_load;    // load the result registers
  } aroc_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;  // last bank flag is being cleared
    logic is_read;     // latched beat is a read command
    logic scan_done;   // every stored range has been issued
    logic pipe_busy;   // compare pipeline still holds reads
  } aroc_status_t;

endpackage

### design/aroc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing else.
module aroc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/aroc_ctrl.sv
// Controller of the address range overlap checker: sequences the clearing
// pass, the table scan, the append and the result handshake. Uses aroc_pkg.
module aroc_ctrl import aroc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output aroc_ctrl_t   ctrl,
  input  aroc_status_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_STORE,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register is free when empty or when its beat leaves now.
  assign out_free = !out_valid_r || !out_stall;

  // Commands and next state.
  always_comb begin
    ctrl      = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        ctrl.clear_en = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        ctrl.latch = in_valid;
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_nxt = sts.is_read ? ST_READ : ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.scan_en = !sts.scan_done;
        if (sts.scan_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        ctrl.store_en = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_READ: begin
        ctrl.flag_rd_en = 1'b1;
        state_nxt       = ST_FINISH;
      end
      ST_FINISH: begin
        ctrl.out_load = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Output valid holds while stalled and rises when a result is loaded.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctrl.out_load) out_valid_nxt = 1'b1;
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // A result never overwrites a beat that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> !(out_valid_r && out_stall))
    else $error("result loaded over a stalled beat");

  // The append waits until the compare pipeline is empty.
  a_store_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.store_en |-> !sts.pipe_busy)
    else $error("range appended while compares are in flight");

  // No table read is issued past the stored entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.scan_en |-> !sts.scan_done)
    else $error("scan read beyond the stored ranges");

  // No input is taken until the clearing pass has finished.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear_en |-> in_stall && !ctrl.latch)
    else $error("input accepted during the clearing pass");

endmodule

### design/aroc_dp.sv
// Datapath of the address range overlap checker: range table, bank flag
// memory, compare pipeline and result registers. Uses aroc_pkg, aroc_ram.
module aroc_dp import aroc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int BANK_COUNT  = BANK_COUNT_DEF,
  parameter int BANK_SHIFT  = BANK_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  aroc_ctrl_t        ctrl,
  output aroc_status_t      sts,
  input  logic              in_command,
  input  logic [ADDR_W-1:0] in_range_start,
  input  logic [ADDR_W-1:0] in_range_end,
  input  logic [BIDX_W-1:0] in_bank_index,
  output logic              out_no_overlap,
  output logic [HITS_W-1:0] out_overlap_count,
  output logic              out_table_full,
  output logic              out_bank_warning
);

  localparam int TABLE_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int BANK_AW  = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam logic [CNT_W-1:0]   DEPTH_C   = CNT_W'(TABLE_DEPTH);
  localparam logic [BANK_AW-1:0] LAST_BANK = BANK_AW'(BANK_COUNT - 1);
  localparam logic [ADDR_W-1:0]  BANKS_C   = ADDR_W'(BANK_COUNT);

  // Latched input beat.
  logic              cmd_r;
  logic [ADDR_W-1:0] ns_r, ne_r;
  logic [BIDX_W-1:0] bidx_r;

  // Table fill and scan pointer.
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              full_r, full_nxt;
  logic              room;

  // Compare pipeline.
  logic                  v1_r;
  logic                  hit2_r;
  logic                  bank_ok2_r;
  logic [BANK_AW-1:0]    bank2_r;
  logic [HITS_W-1:0]     hits_r, hits_nxt;
  logic [2*ADDR_W-1:0]   tbl_rdata;
  logic [ADDR_W-1:0]     os, oe, ov_end, ov_bank;
  logic                  overlap;

  // Bank flag memory and clearing pass.
  logic [BANK_AW-1:0] clr_idx_r;
  logic               flag_we;
  logic [BANK_AW-1:0] flag_waddr;
  logic               flag_rdata;
  logic [ADDR_W-1:0]  bidx_ext;
  logic               bidx_ok;

  // Capture of the input beat.
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r  <= in_command;
      ns_r   <= in_range_start;
      ne_r   <= in_range_end;
      bidx_r <= in_bank_index;
    end
  end

  assign room = (count_r < DEPTH_C);

  // Scan pointer, fill count and full flag.
  always_comb begin
    idx_nxt   = idx_r;
    count_nxt = count_r;
    full_nxt  = full_r;
    if (ctrl.latch) begin
      idx_nxt = '0;
    end else if (ctrl.scan_en) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if (ctrl.store_en) begin
      full_nxt = !room;
      if (room) count_nxt = count_r + CNT_W'(1);
    end
  end

  // Range table: start in the upper half, end in the lower half.
  aroc_ram #(
    .WIDTH (2 * ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ctrl.store_en && room),
    .waddr (count_r[TABLE_AW-1:0]),
    .wdata ({ns_r, ne_r}),
    .re    (ctrl.scan_en),
    .raddr (idx_r[TABLE_AW-1:0]),
    .rdata (tbl_rdata)
  );

  // Overlap test and end bank of the overlap.
  assign os      = tbl_rdata[2*ADDR_W-1:ADDR_W];
  assign oe      = tbl_rdata[ADDR_W-1:0];
  assign overlap = !((ns_r > oe) || (ne_r < os));
  assign ov_end  = (oe < ne_r) ? oe : ne_r;
  assign ov_bank = ov_end >> BANK_SHIFT;

  // Saturating overlap counter.
  always_comb begin
    hits_nxt = hits_r;
    if (ctrl.latch) begin
      hits_nxt = '0;
    end else if (hit2_r && (hits_r != HITS_MAX)) begin
      hits_nxt = hits_r + HITS_W'(1);
    end
  end

  // Control registers of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      full_r    <= 1'b0;
      v1_r      <= 1'b0;
      hit2_r    <= 1'b0;
      hits_r    <= '0;
      clr_idx_r <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      full_r  <= full_nxt;
      v1_r    <= ctrl.scan_en;
      hit2_r  <= v1_r && overlap;
      hits_r  <= hits_nxt;
      if (ctrl.clear_en) clr_idx_r <= clr_idx_r + BANK_AW'(1);
    end
  end

  // Bank of a found overlap, carried to the flag write.
  always_ff @(posedge clk) begin
    bank_ok2_r <= (ov_bank < BANKS_C);
    bank2_r    <= ov_bank[BANK_AW-1:0];
  end

  // Flag writes: zeros during the clearing pass, sticky ones afterwards.
  assign flag_we    = ctrl.clear_en || (hit2_r && bank_ok2_r);
  assign flag_waddr = ctrl.clear_en ? clr_idx_r : bank2_r;
  assign bidx_ext   = ADDR_W'(bidx_r);
  assign bidx_ok    = (bidx_ext < BANKS_C);

  aroc_ram #(
    .WIDTH (1),
    .DEPTH (BANK_COUNT)
  ) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (!ctrl.clear_en),
    .re    (ctrl.flag_rd_en),
    .raddr (bidx_ext[BANK_AW-1:0]),
    .rdata (flag_rdata)
  );

  // Result registers.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      if (cmd_r == CMD_READ) begin
        out_no_overlap    <= 1'b0;
        out_overlap_count <= '0;
        out_table_full    <= 1'b0;
        out_bank_warning  <= bidx_ok && flag_rdata;
      end else begin
        out_no_overlap    <= (hits_r == '0);
        out_overlap_count <= hits_r;
        out_table_full    <= full_r;
        out_bank_warning  <= 1'b0;
      end
    end
  end

  // Status to the controller.
  assign sts.clear_done = (clr_idx_r == LAST_BANK);
  assign sts.is_read    = (cmd_r == CMD_READ);
  assign sts.scan_done  = (idx_r == count_r);
  assign sts.pipe_busy  = v1_r || hit2_r;

endmodule

### design/address_range_overlap_checker_core.sv
// Address range overlap checker, top level.
// Add: the scan reads one stored range per cycle, then the compare pipeline drains
// and the range is appended before the result loads. Read: the bank flag is read, then the result loads.
// One item at a time: the next beat is taken the cycle after the result loads, and a
// stalled result holds the block. After reset a clearing pass zeroes the bank flags
// with the input stalled. Uses aroc_pkg, aroc_ctrl, aroc_dp.
module address_range_overlap_checker_core import aroc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int BANK_COUNT  = BANK_COUNT_DEF,
  parameter int BANK_SHIFT  = BANK_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [ADDR_W-1:0] in_range_start,
  input  logic [ADDR_W-1:0] in_range_end,
  input  logic [BIDX_W-1:0] in_bank_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_no_overlap,
  output logic [HITS_W-1:0] out_overlap_count,
  output logic              out_table_full,
  output logic              out_bank_warning
);

  aroc_ctrl_t   ctrl;
  aroc_status_t sts;

  // Sequencer.
  aroc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .sts       (sts)
  );

  // Table, flags and compare logic.
  aroc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .BANK_COUNT  (BANK_COUNT),
    .BANK_SHIFT  (BANK_SHIFT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .sts               (sts),
    .in_command        (in_command),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .in_bank_index     (in_bank_index),
    .out_no_overlap    (out_no_overlap),
    .out_overlap_count (out_overlap_count),
    .out_table_full    (out_table_full),
    .out_bank_warning  (out_bank_warning)
  );

endmodule
